### hw/rtl/lsfp_pkg.sv
// ----------------------------------------------------------------------------
// lsfp_pkg
// Shared types and constants for the 9-bit SPI LCD frame packer.
// ----------------------------------------------------------------------------
package lsfp_pkg;

  // APB address width: two 32-bit registers at byte addresses 0 and 4
  localparam int PADDR_W = 3;

  // register index codes (paddr[2])
  localparam logic REG_COLUMN_WINDOW = 1'b0;
  localparam logic REG_ROW_WINDOW    = 1'b1;

  localparam logic [31:0] COLUMN_WINDOW_RST = 32'd239;
  localparam logic [31:0] ROW_WINDOW_RST    = 32'd319;

  // display commands
  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;
  localparam logic [7:0] CMD_NOP   = 8'h00;

  // D/C flag of a symbol
  localparam logic DC_CMD  = 1'b0;
  localparam logic DC_DATA = 1'b1;

  // symbol positions within one item
  typedef logic [3:0] sym_idx_t;
  localparam sym_idx_t IDX_CASET = 4'd0;
  localparam sym_idx_t IDX_COL3  = 4'd1;
  localparam sym_idx_t IDX_COL2  = 4'd2;
  localparam sym_idx_t IDX_COL1  = 4'd3;
  localparam sym_idx_t IDX_COL0  = 4'd4;
  localparam sym_idx_t IDX_RASET = 4'd5;
  localparam sym_idx_t IDX_ROW3  = 4'd6;
  localparam sym_idx_t IDX_ROW2  = 4'd7;
  localparam sym_idx_t IDX_ROW1  = 4'd8;
  localparam sym_idx_t IDX_ROW0  = 4'd9;
  localparam sym_idx_t IDX_RAMWR = 4'd10;
  localparam sym_idx_t IDX_PIX0  = 4'd11;
  localparam sym_idx_t IDX_PIX1  = 4'd12;
  localparam sym_idx_t IDX_PIX2  = 4'd13;
  localparam sym_idx_t IDX_PIX3  = 4'd14;
  localparam sym_idx_t IDX_NOP   = 4'd15;

  // classified item as it travels through the queue
  typedef struct packed {
    logic [31:0] pixel_word;
    logic        last_word;
    sym_idx_t    start_idx;
  } lsfp_job_t;

  typedef struct packed {
    logic [31:0] column_window;
    logic [31:0] row_window;
  } lsfp_cfg_t;

endpackage

### hw/rtl/lsfp_if.sv
// ----------------------------------------------------------------------------
// lsfp_in_if / lsfp_out_if
// Valid/ready channels for pixel items in and packed bytes out.
// ----------------------------------------------------------------------------
interface lsfp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        first_word;
  logic        last_word;

  modport source (output valid, pixel_word, first_word, last_word, input ready);
  modport sink   (input valid, pixel_word, first_word, last_word, output ready);
endinterface

interface lsfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

### hw/rtl/lsfp_cfg.sv
// ----------------------------------------------------------------------------
// lsfp_cfg
// APB register file holding the column and row window registers.
// ----------------------------------------------------------------------------
module lsfp_cfg
  import lsfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lsfp_cfg_t          cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_window <= COLUMN_WINDOW_RST;
      cfg.row_window    <= ROW_WINDOW_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_COLUMN_WINDOW: cfg.column_window <= pwdata;
        REG_ROW_WINDOW:    cfg.row_window    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COLUMN_WINDOW: prdata = cfg.column_window;
      REG_ROW_WINDOW:    prdata = cfg.row_window;
      default:           prdata = '0;
    endcase
  end

endmodule

### hw/rtl/lsfp_front.sv
// ----------------------------------------------------------------------------
// lsfp_front
// Accept items, classify them by first symbol, and queue them (two entries).
// ----------------------------------------------------------------------------
module lsfp_front
  import lsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lsfp_in_if.sink     in_ch,
  output logic        q_valid,
  output lsfp_job_t   q_job,
  input  logic        q_ready
);

  lsfp_job_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  lsfp_job_t  job_in;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;
  assign q_valid     = (count != 2'd0);
  assign q_job       = mem[rd_ptr];

  // a frame start begins at the window header, any other item at its pixel data
  always_comb begin
    job_in.pixel_word = in_ch.pixel_word;
    job_in.last_word  = in_ch.last_word;
    job_in.start_idx  = in_ch.first_word ? IDX_CASET : IDX_PIX0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/lsfp_back.sv
// ----------------------------------------------------------------------------
// lsfp_back
// Walk the symbols of each queued item and pack them into bytes.
// ----------------------------------------------------------------------------
module lsfp_back
  import lsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lsfp_cfg_t   cfg,
  input  logic        q_valid,
  input  lsfp_job_t   q_job,
  output logic        q_ready,
  lsfp_out_if.source  out_ch
);

  // sequencer
  sym_idx_t    idx;
  logic        active;
  sym_idx_t    cur_idx;
  logic [8:0]  sym;
  logic        job_end;
  logic        push;

  // bit accumulator: pending bits right-aligned in acc, cnt of them valid
  logic [15:0] acc;
  logic [4:0]  cnt;
  logic        flush;
  logic [15:0] acc_next;
  logic [4:0]  cnt_next;
  logic [4:0]  base_cnt;
  logic        cnt_ge8;

  // output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        frame_end;
  logic        out_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic [3:0]  shr;
  logic [3:0]  shl;
  logic [15:0] acc_shr;
  logic [15:0] acc_shl;

  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_byte;
  assign out_ch.frame_end = frame_end;

  assign cur_idx = active ? idx : q_job.start_idx;

  always_comb begin
    case (cur_idx)
      IDX_CASET: sym = {DC_CMD,  CMD_CASET};
      IDX_COL3:  sym = {DC_DATA, cfg.column_window[31:24]};
      IDX_COL2:  sym = {DC_DATA, cfg.column_window[23:16]};
      IDX_COL1:  sym = {DC_DATA, cfg.column_window[15:8]};
      IDX_COL0:  sym = {DC_DATA, cfg.column_window[7:0]};
      IDX_RASET: sym = {DC_CMD,  CMD_RASET};
      IDX_ROW3:  sym = {DC_DATA, cfg.row_window[31:24]};
      IDX_ROW2:  sym = {DC_DATA, cfg.row_window[23:16]};
      IDX_ROW1:  sym = {DC_DATA, cfg.row_window[15:8]};
      IDX_ROW0:  sym = {DC_DATA, cfg.row_window[7:0]};
      IDX_RAMWR: sym = {DC_CMD,  CMD_RAMWR};
      IDX_PIX0:  sym = {DC_DATA, q_job.pixel_word[15:8]};
      IDX_PIX1:  sym = {DC_DATA, q_job.pixel_word[7:0]};
      IDX_PIX2:  sym = {DC_DATA, q_job.pixel_word[31:24]};
      IDX_PIX3:  sym = {DC_DATA, q_job.pixel_word[23:16]};
      IDX_NOP:   sym = {DC_CMD,  CMD_NOP};
      default:   sym = {DC_CMD,  CMD_NOP};
    endcase
  end

  assign job_end = (cur_idx == IDX_NOP) || ((cur_idx == IDX_PIX3) && !q_job.last_word);

  // byte extraction: a whole byte from the top of the pending bits, or the
  // zero-padded remainder while flushing the end of a frame
  assign out_free = !out_valid || out_ch.ready;
  assign cnt_ge8  = (cnt >= 5'd8);
  assign emit     = out_free && (cnt_ge8 || (flush && (cnt != 5'd0)));
  assign shr      = 4'(cnt - 5'd8);
  assign shl      = 4'(5'd8 - cnt);
  assign acc_shr  = acc >> shr;
  assign acc_shl  = acc << shl;
  assign emit_byte = cnt_ge8 ? acc_shr[7:0] : acc_shl[7:0];
  assign emit_end  = flush && (!cnt_ge8 || (cnt == 5'd8));

  always_comb begin
    if (emit) begin
      base_cnt = cnt_ge8 ? 5'(cnt - 5'd8) : 5'd0;
    end else begin
      base_cnt = cnt;
    end
  end

  // take a symbol only when fewer than a byte of bits stays pending
  assign push    = q_valid && !flush && (base_cnt <= 5'd7);
  assign q_ready = push && job_end;

  always_comb begin
    acc_next = acc;
    cnt_next = base_cnt;
    if (push) begin
      if (cur_idx == IDX_CASET) begin
        // new frame: drop leftover bits of an unterminated frame
        acc_next = {7'd0, sym};
        cnt_next = 5'd9;
      end else begin
        acc_next = {acc[6:0], sym};
        cnt_next = base_cnt + 5'd9;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= IDX_CASET;
      active <= 1'b0;
      acc    <= '0;
      cnt    <= '0;
      flush  <= 1'b0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
      if (push) begin
        idx    <= sym_idx_t'(cur_idx + 4'd1);
        active <= !job_end;
      end
      if (push && (cur_idx == IDX_NOP)) begin
        flush <= 1'b1;
      end else if (emit && emit_end) begin
        flush <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= emit_byte;
      frame_end <= emit_end;
    end
  end

endmodule

### hw/rtl/lcd_9bit_spi_frame_packer_unit.sv
// ----------------------------------------------------------------------------
// lcd_9bit_spi_frame_packer_unit
// Packs pixel words into a three-wire 9-bit SPI byte stream with window
// header, write-memory command, trailing zero command and byte padding.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  --------------------------------------
//  in_ch    in   valid/ready            pixel_word[31:0], first_word, last_word
//  out_ch   out  valid/ready            out_byte[7:0], frame_end
//  apb      in   psel/penable, pready   paddr[2:0], pwdata/prdata[31:0]
//
//  Flow: one output byte per clock at most, set by the byte-wide output
//  register; a plain item is four symbols (36 bits). A frame start adds 11
//  header symbols, a frame end one command symbol plus a flush that drains
//  the last two bytes, zero-padding the final one where needed; no symbol is
//  taken during the flush.
//  Reset: synchronous, active high; clears the queue, the pending bits and the
//  output valid, and loads the window registers with 239 and 319.
//  Stalls: a two-entry queue sits between intake and packing, so items are
//  taken while bytes wait on out_ch until it fills; then intake stalls too.
//
module lcd_9bit_spi_frame_packer_unit
  import lsfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lsfp_in_if.sink            in_ch,
  lsfp_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  lsfp_cfg_t cfg;
  logic      q_valid;
  logic      q_ready;
  lsfp_job_t q_job;

  // window registers; the user must write them only while the packer is idle (not enforced)
  lsfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // intake: tag each item with its first symbol and hold it in the queue
  lsfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_ready (q_ready)
  );

  // packing: one byte out per cycle at most; pops an item on its last symbol
  lsfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

### hw/rtl/lsfp_checker.sv
// ----------------------------------------------------------------------------
// lsfp_checker
// Port-level checks for the frame packer, bound to the top level.
// ----------------------------------------------------------------------------
module lsfp_checker
  import lsfp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_byte,
  input logic               frame_end,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);

  // no byte is offered right after reset
  a_rst_out_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_ch valid after reset");

  // the queue is empty after reset, so an item can be taken
  a_rst_in_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ch not ready after reset");

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("out_ch payload changed while stalled");

  // a written column window register reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[2] == REG_COLUMN_WINDOW)) ##1
    (paddr[2] == REG_COLUMN_WINDOW) |-> prdata == $past(pwdata))
    else $error("column window readback mismatch");

endmodule

bind lcd_9bit_spi_frame_packer_unit lsfp_checker u_lsfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .frame_end (out_ch.frame_end),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
